// ===== rtl/core/all_pairs_shortest_path_macros.svh =====
// Assertion macros used by the shortest path top level
`ifndef ALL_PAIRS_SHORTEST_PATH_MACROS_SVH
`define ALL_PAIRS_SHORTEST_PATH_MACROS_SVH

// Check a condition on every clock edge outside reset
`define APSP_ASSERT_HOLDS(label, cond) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond)) \
        else $error("apsp assertion failed");

// Check that a condition implies another in the same cycle
`define APSP_ASSERT_IMPLIES(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("apsp assertion failed");

// Check that a condition implies another in the next cycle
`define APSP_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("apsp assertion failed");

`endif

// ===== rtl/core/apsp_pkg.sv =====
// Shared types and constants of the shortest path block
`timescale 1ns / 1ps
`default_nettype none

package apsp_pkg;

    localparam int MAX_NODES   = 64;
    localparam int NODE_BITS   = 6;
    localparam int CNT_BITS    = 7;
    localparam int ADDR_BITS   = 2 * NODE_BITS;
    localparam int WEIGHT_BITS = 16;
    localparam int DIST_BITS   = 24;
    localparam int STORE_DEPTH = MAX_NODES * MAX_NODES;

    localparam logic [DIST_BITS-1:0] DIST_INF = {DIST_BITS{1'b1}};
    localparam logic [CNT_BITS-1:0]  NODE_COUNT_RESET = CNT_BITS'(MAX_NODES);

    localparam logic [1:0] MODE_WRITE = 2'd0;
    localparam logic [1:0] MODE_RUN   = 2'd1;
    localparam logic [1:0] MODE_READ  = 2'd2;

    typedef struct packed {
        logic                 a_en;
        logic [ADDR_BITS-1:0] a_addr;
        logic                 b_en;
        logic [ADDR_BITS-1:0] b_addr;
        logic                 we;
        logic [ADDR_BITS-1:0] waddr;
        logic [DIST_BITS-1:0] wdata;
    } ram_req_t;

    typedef struct packed {
        logic busy;
        logic done_req;
    } ctrl_stat_t;

    typedef struct packed {
        logic                 done_res;
        logic                 unreachable;
        logic [DIST_BITS-1:0] distance;
    } res_t;

endpackage

`default_nettype wire

// ===== rtl/core/apsp_ram.sv =====
// Generic synchronous RAM, one write port and two registered read ports
`timescale 1ns / 1ps
`default_nettype none

module apsp_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  wire logic                     clk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire logic [WIDTH-1:0]         wdata,
    input  wire logic                     a_en,
    input  wire logic [$clog2(DEPTH)-1:0] a_addr,
    output logic      [WIDTH-1:0]         a_q,
    input  wire logic                     b_en,
    input  wire logic [$clog2(DEPTH)-1:0] b_addr,
    output logic      [WIDTH-1:0]         b_q
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (a_en)
        begin
            a_q <= mem[a_addr];
        end
        if (b_en)
        begin
            b_q <= mem[b_addr];
        end
    end

endmodule

`default_nettype wire

// ===== rtl/core/apsp_resq.sv =====
// Two-entry result queue in front of the master port
`timescale 1ns / 1ps
`default_nettype none

module apsp_resq (
    input  wire logic          clk,
    input  wire logic          rst_n,
    input  wire logic          push,
    input  wire apsp_pkg::res_t push_data,
    input  wire logic          pop,
    output logic               valid,
    output apsp_pkg::res_t     data,
    output logic [1:0]         cnt
);

    apsp_pkg::res_t mem_reg [2];
    logic           wr_ptr_reg;
    logic           wr_ptr_next;
    logic           rd_ptr_reg;
    logic           rd_ptr_next;
    logic [1:0]     cnt_reg;
    logic [1:0]     cnt_next;

    always_comb
    begin
        wr_ptr_next = push ? ~wr_ptr_reg : wr_ptr_reg;
        rd_ptr_next = pop ? ~rd_ptr_reg : rd_ptr_reg;
        cnt_next    = cnt_reg + {1'b0, push} - {1'b0, pop};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            cnt_reg    <= 2'd0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            cnt_reg    <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            mem_reg[wr_ptr_reg] <= push_data;
        end
    end

    assign valid = (cnt_reg != 2'd0);
    assign data  = mem_reg[rd_ptr_reg];
    assign cnt   = cnt_reg;

endmodule

`default_nettype wire

// ===== rtl/core/apsp_ctrl.sv =====
// Closure sequencer: walks k, i, j and updates the store read-modify-write
`timescale 1ns / 1ps
`default_nettype none

module apsp_ctrl (
    input  wire logic                                clk,
    input  wire logic                                rst_n,
    input  wire logic                                start,
    input  wire logic [apsp_pkg::CNT_BITS-1:0]       node_count,
    input  wire logic [apsp_pkg::DIST_BITS-1:0]      a_q,
    input  wire logic [apsp_pkg::DIST_BITS-1:0]      b_q,
    input  wire logic                                done_ack,
    output apsp_pkg::ram_req_t                       req,
    output apsp_pkg::ctrl_stat_t                     stat
);

    localparam logic [2:0] ST_IDLE  = 3'd0;
    localparam logic [2:0] ST_LEAD  = 3'd1;
    localparam logic [2:0] ST_SWEEP = 3'd2;
    localparam logic [2:0] ST_DRAIN = 3'd3;
    localparam logic [2:0] ST_DONE  = 3'd4;

    localparam int NB = apsp_pkg::NODE_BITS;
    localparam int DB = apsp_pkg::DIST_BITS;

    logic [2:0]                       state_reg;
    logic [2:0]                       state_next;
    logic [NB-1:0]                    k_reg;
    logic [NB-1:0]                    k_next;
    logic [NB-1:0]                    i_reg;
    logic [NB-1:0]                    i_next;
    logic [NB-1:0]                    j_reg;
    logic [NB-1:0]                    j_next;
    logic [NB-1:0]                    last_reg;
    logic [NB-1:0]                    last_next;
    logic                             st_v_reg;
    logic                             st_v_next;
    logic [apsp_pkg::ADDR_BITS-1:0]   st_addr_reg;
    logic [DB-1:0]                    dik_reg;
    logic [apsp_pkg::CNT_BITS-1:0]    n_eff;
    logic [DB:0]                      sum;
    logic [DB-1:0]                    via;
    logic                             wr_en;

    always_comb
    begin
        n_eff = (node_count > apsp_pkg::CNT_BITS'(apsp_pkg::MAX_NODES))
              ? apsp_pkg::CNT_BITS'(apsp_pkg::MAX_NODES) : node_count;
        sum   = {1'b0, dik_reg} + {1'b0, a_q};
        if (dik_reg == apsp_pkg::DIST_INF || a_q == apsp_pkg::DIST_INF
            || sum >= {1'b0, apsp_pkg::DIST_INF})
        begin
            via = apsp_pkg::DIST_INF;
        end
        else
        begin
            via = sum[DB-1:0];
        end
        wr_en = st_v_reg && (via < b_q);
    end

    always_comb
    begin
        state_next = state_reg;
        k_next     = k_reg;
        i_next     = i_reg;
        j_next     = j_reg;
        last_next  = last_reg;
        st_v_next  = 1'b0;
        req.a_en   = 1'b0;
        req.a_addr = {i_reg, k_reg};
        req.b_en   = 1'b0;
        req.b_addr = {i_reg, j_reg};
        req.we     = wr_en;
        req.waddr  = st_addr_reg;
        req.wdata  = via;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (start)
                begin
                    k_next    = '0;
                    i_next    = '0;
                    j_next    = '0;
                    last_next = NB'(n_eff - 1'b1);
                    state_next = (n_eff == '0) ? ST_DONE : ST_LEAD;
                end
            end
            ST_LEAD:
            begin
                req.a_en   = 1'b1;
                j_next     = '0;
                state_next = ST_SWEEP;
            end
            ST_SWEEP:
            begin
                req.a_en   = 1'b1;
                req.a_addr = {k_reg, j_reg};
                req.b_en   = 1'b1;
                st_v_next  = 1'b1;
                j_next     = j_reg + 1'b1;
                if (j_reg == last_reg)
                begin
                    if (i_reg == last_reg)
                    begin
                        i_next = '0;
                        if (k_reg == last_reg)
                        begin
                            state_next = ST_DRAIN;
                        end
                        else
                        begin
                            k_next     = k_reg + 1'b1;
                            state_next = ST_LEAD;
                        end
                    end
                    else
                    begin
                        i_next     = i_reg + 1'b1;
                        state_next = ST_LEAD;
                    end
                end
            end
            ST_DRAIN:
            begin
                state_next = ST_DONE;
            end
            ST_DONE:
            begin
                if (done_ack)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            k_reg     <= '0;
            i_reg     <= '0;
            j_reg     <= '0;
            last_reg  <= '0;
            st_v_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            k_reg     <= k_next;
            i_reg     <= i_next;
            j_reg     <= j_next;
            last_reg  <= last_next;
            st_v_reg  <= st_v_next;
        end
    end

    always_ff @(posedge clk)
    begin
        st_addr_reg <= {i_reg, j_reg};
        if (state_reg == ST_SWEEP && j_reg == '0)
        begin
            dik_reg <= a_q;
        end
    end

    assign stat.busy     = (state_reg != ST_IDLE);
    assign stat.done_req = (state_reg == ST_DONE);

endmodule

`default_nettype wire

// ===== rtl/core/all_pairs_shortest_path.sv =====
// Top level of the all-pairs shortest path block
//
// Slave stream: one word per item; s_tuser carries the mode (write, run, read),
// s_tdata carries row, col and the edge weight, whose top bit flags no edge. Master stream: one word
// per result; m_tdata carries the distance and the unreachable flag, m_tuser
// is set on the word that ends a run and clear on read data.
// cfg_valid/cfg_data set node_count; cfg_ready is always high.
// Write items go straight to the distance store.
// Read items are taken one per cycle while the result queue has room; the
// store's read port registers the distance, which then enters the result queue.
// A run item closes over n = min(node_count, 64) nodes, doing one
// read-modify-write of the store per cycle through its two read ports
// and one write port, plus a lead state per row to fetch the pivot column.
// No item is taken during a run.
// A two-word result queue decouples the master side; when it backs up,
// s_tready falls and the block holds. Reset empties the queue, stops any run
// and sets node_count to 64; the store contents are undefined until written.
`timescale 1ns / 1ps
`default_nettype none
`include "all_pairs_shortest_path_macros.svh"

module all_pairs_shortest_path (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        s_tvalid,
    output logic             s_tready,
    input  wire logic [31:0] s_tdata,   // row [5:0], col [11:6], weight [28:12], zero
    input  wire logic [1:0]  s_tuser,   // mode [1:0]
    output logic             m_tvalid,
    input  wire logic        m_tready,
    output logic      [31:0] m_tdata,   // distance [23:0], unreachable [24], zero
    output logic             m_tuser,   // done_res [0]
    input  wire logic        cfg_valid,
    output logic             cfg_ready,
    input  wire logic [6:0]  cfg_data   // node_count [6:0]
);

    localparam int NB = apsp_pkg::NODE_BITS;
    localparam int DB = apsp_pkg::DIST_BITS;
    localparam int WB = apsp_pkg::WEIGHT_BITS;

    logic [apsp_pkg::CNT_BITS-1:0] node_count_reg;
    logic                          pend_reg;
    logic                          pend_next;

    logic [NB-1:0]             row;
    logic [NB-1:0]             col;
    logic [WB:0]               weight;
    logic                      accept;
    logic [DB-1:0]             wval;
    logic [DB-1:0]             a_q;
    logic [DB-1:0]             b_q;
    apsp_pkg::ram_req_t        creq;
    apsp_pkg::ram_req_t        mreq;
    apsp_pkg::ctrl_stat_t      stat;
    apsp_pkg::res_t            push_data;
    apsp_pkg::res_t            q_data;
    logic                      push;
    logic                      pop;
    logic                      done_ack;
    logic [1:0]                q_cnt;
    logic [2:0]                occ;

    assign row    = s_tdata[NB-1:0];
    assign col    = s_tdata[2*NB-1:NB];
    assign weight = s_tdata[2*NB+WB:2*NB];

    assign pop      = m_tvalid && m_tready;
    assign occ      = {1'b0, q_cnt} + {2'b00, pend_reg} - {2'b00, pop};
    assign s_tready = !stat.busy && (occ < 3'd2);
    assign accept   = s_tvalid && s_tready;
    assign done_ack = stat.done_req && !pend_reg && ((q_cnt != 2'd2) || pop);
    assign cfg_ready = 1'b1;

    always_comb
    begin
        if (row == col)
        begin
            wval = '0;
        end
        else if (weight[WB])
        begin
            wval = apsp_pkg::DIST_INF;
        end
        else
        begin
            wval = DB'(weight[WB-1:0]);
        end
    end

    always_comb
    begin
        if (stat.busy)
        begin
            mreq = creq;
        end
        else
        begin
            mreq.a_en   = 1'b0;
            mreq.a_addr = {row, col};
            mreq.b_en   = accept && (s_tuser == apsp_pkg::MODE_READ);
            mreq.b_addr = {row, col};
            mreq.we     = accept && (s_tuser == apsp_pkg::MODE_WRITE);
            mreq.waddr  = {row, col};
            mreq.wdata  = wval;
        end
        pend_next = accept && (s_tuser == apsp_pkg::MODE_READ);
    end

    always_comb
    begin
        push = pend_reg || done_ack;
        if (pend_reg)
        begin
            push_data.done_res    = 1'b0;
            push_data.unreachable = (b_q == apsp_pkg::DIST_INF);
            push_data.distance    = b_q;
        end
        else
        begin
            push_data.done_res    = 1'b1;
            push_data.unreachable = 1'b0;
            push_data.distance    = '0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            node_count_reg <= apsp_pkg::NODE_COUNT_RESET;
            pend_reg       <= 1'b0;
        end
        else
        begin
            if (cfg_valid && cfg_ready)
            begin
                node_count_reg <= cfg_data;
            end
            pend_reg <= pend_next;
        end
    end

    apsp_ram #(
        .WIDTH (DB),
        .DEPTH (apsp_pkg::STORE_DEPTH)
    ) u_store (
        .clk    (clk),
        .we     (mreq.we),
        .waddr  (mreq.waddr),
        .wdata  (mreq.wdata),
        .a_en   (mreq.a_en),
        .a_addr (mreq.a_addr),
        .a_q    (a_q),
        .b_en   (mreq.b_en),
        .b_addr (mreq.b_addr),
        .b_q    (b_q)
    );

    apsp_ctrl u_ctrl (
        .clk        (clk),
        .rst_n      (rst_n),
        .start      (accept && (s_tuser == apsp_pkg::MODE_RUN)),
        .node_count (node_count_reg),
        .a_q        (a_q),
        .b_q        (b_q),
        .done_ack   (done_ack),
        .req        (creq),
        .stat       (stat)
    );

    apsp_resq u_resq (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .push_data (push_data),
        .pop       (pop),
        .valid     (m_tvalid),
        .data      (q_data),
        .cnt       (q_cnt)
    );

    assign m_tdata = {7'b0, q_data.unreachable, q_data.distance};
    assign m_tuser = q_data.done_res;

    `APSP_ASSERT_IMPLIES(a_busy_no_accept, stat.busy, !s_tready)
    `APSP_ASSERT_HOLDS(a_single_push, !(pend_reg && done_ack))
    `APSP_ASSERT_HOLDS(a_queue_bound, q_cnt != 2'd3)
    `APSP_ASSERT_NEXT(a_read_pending, accept && (s_tuser == apsp_pkg::MODE_READ), pend_reg)

endmodule

`default_nettype wire

// ===== verif/all_pairs_shortest_path_test.sv =====
// Self-checking stream testbench for the all-pairs shortest path block
`timescale 1ns / 1ps

module all_pairs_shortest_path_test;

    localparam int NB = apsp_pkg::NODE_BITS;
    localparam int WB = apsp_pkg::WEIGHT_BITS;
    localparam int DB = apsp_pkg::DIST_BITS;
    localparam int MN = apsp_pkg::MAX_NODES;
    localparam logic [1:0] MODE_NONE = 2'd3;
    localparam int FILL_NODES = 16;
    localparam int RANDOM_ITEMS = 260;
    localparam int CYCLE_LIMIT = 3_000_000;

    class distance_book;
        logic [DB-1:0] dist_mem [apsp_pkg::STORE_DEPTH];
        int unsigned node_count = MN;
        apsp_pkg::res_t pending_words [$];
        int failures = 0;

        function int pending();
            return pending_words.size();
        endfunction

        function void note_item(logic [1:0] mode, logic [NB-1:0] row,
                                logic [NB-1:0] col, logic [WB:0] weight);
            apsp_pkg::res_t word;
            int n;
            logic [DB:0] via;
            word = '0;
            case (mode)
                apsp_pkg::MODE_WRITE:
                begin
                    if (row == col)
                        dist_mem[{row, col}] = '0;
                    else if (weight[WB])
                        dist_mem[{row, col}] = apsp_pkg::DIST_INF;
                    else
                        dist_mem[{row, col}] = DB'(weight[WB-1:0]);
                end
                apsp_pkg::MODE_RUN:
                begin
                    n = (node_count > MN) ? MN : int'(node_count);
                    for (int k = 0; k < n; k++)
                        for (int i = 0; i < n; i++)
                            for (int j = 0; j < n; j++)
                            begin
                                if (dist_mem[i*MN+k] == apsp_pkg::DIST_INF ||
                                    dist_mem[k*MN+j] == apsp_pkg::DIST_INF)
                                    via = {1'b0, apsp_pkg::DIST_INF};
                                else
                                    via = {1'b0, dist_mem[i*MN+k]} +
                                          {1'b0, dist_mem[k*MN+j]};
                                if (via > {1'b0, apsp_pkg::DIST_INF})
                                    via = {1'b0, apsp_pkg::DIST_INF};
                                if (via < {1'b0, dist_mem[i*MN+j]})
                                    dist_mem[i*MN+j] = via[DB-1:0];
                            end
                    word.done_res = 1'b1;
                    pending_words = {pending_words, word};
                end
                apsp_pkg::MODE_READ:
                begin
                    word.distance = dist_mem[{row, col}];
                    word.unreachable = (word.distance == apsp_pkg::DIST_INF);
                    pending_words = {pending_words, word};
                end
                default: ;
            endcase
        endfunction

        function void check_word(logic [DB-1:0] distance, logic unreachable,
                                 logic done_res);
            apsp_pkg::res_t want;
            if (pending_words.size() == 0)
            begin
                $error("unexpected word: distance %0d unreachable %0b done_res %0b",
                       distance, unreachable, done_res);
                failures++;
                return;
            end
            want = pending_words.pop_front();
            if (distance !== want.distance)
            begin
                $error("distance: expected %0d, got %0d", want.distance, distance);
                failures++;
            end
            if (unreachable !== want.unreachable)
            begin
                $error("unreachable: expected %0b, got %0b", want.unreachable, unreachable);
                failures++;
            end
            if (done_res !== want.done_res)
            begin
                $error("done_res: expected %0b, got %0b", want.done_res, done_res);
                failures++;
            end
        endfunction
    endclass

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [31:0] s_tdata = '0;     // row [5:0], col [11:6], weight [28:12], zero
    logic [1:0]  s_tuser = '0;     // mode [1:0]
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [31:0] m_tdata;          // distance [23:0], unreachable [24], zero
    logic        m_tuser;          // done_res [0]
    logic        cfg_valid = 1'b0;
    logic        cfg_ready;
    logic [6:0]  cfg_data = '0;    // node_count [6:0]

    distance_book book;
    int send_idle = 0;
    int recv_idle = 0;
    int stall_left = 0;
    int unsigned cycle_count = 0;

    all_pairs_shortest_path DUT (
        .clk       (clk),
        .rst_n     (rst_n),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_data  (cfg_data)
    );

    always #5 clk = ~clk;

    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("all_pairs_shortest_path_test failed");
            $finish;
        end
    end

    function automatic logic [NB-1:0] pick_node();
        return NB'($urandom_range(0, FILL_NODES - 1));
    endfunction

    function automatic logic [NB-1:0] pick_far_node();
        if ($urandom_range(0, 9) < 7)
            return NB'($urandom_range(0, FILL_NODES - 1));
        return NB'($urandom_range(0, MN - 1));
    endfunction

    function automatic logic [WB:0] pick_weight();
        case ($urandom_range(0, 9))
            0, 1, 2: return '1;
            3:       return {1'b1, WB'($urandom)};
            4:       return (WB + 1)'($urandom);
            default: return (WB + 1)'($urandom_range(0, 60));
        endcase
    endfunction

    task automatic offer_word(input logic [1:0] mode, input logic [NB-1:0] row,
                              input logic [NB-1:0] col,
                              input logic [WB:0] weight);
        while ($urandom_range(0, 99) < send_idle)
        begin
            s_tvalid <= 1'b0;
            @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tuser <= mode;
        s_tdata <= {3'b000, weight, col, row};
        do @(posedge clk); while (!s_tready);
        book.note_item(mode, row, col, weight);
    endtask

    task automatic drain_results();
        s_tvalid <= 1'b0;
        do @(posedge clk); while (book.pending() != 0);
    endtask

    task automatic load_node_count(input logic [apsp_pkg::CNT_BITS-1:0] count);
        drain_results();
        repeat (8) @(posedge clk);
        cfg_valid <= 1'b1;
        cfg_data <= count;
        do @(posedge clk); while (!cfg_ready);
        cfg_valid <= 1'b0;
        book.node_count = count;
    endtask

    // receive side: check each accepted word, then choose next ready
    initial
    begin
        @(posedge rst_n);
        forever
        begin
            @(posedge clk);
            if (m_tvalid && m_tready)
                book.check_word(m_tdata[DB-1:0], m_tdata[DB], m_tuser);
            if (stall_left > 0)
            begin
                stall_left--;
                m_tready <= 1'b0;
            end
            else
                m_tready <= ($urandom_range(0, 99) >= recv_idle);
        end
    end

    initial
    begin
        int counted;
        int next_cfg;
        int pick;
        bit squeezed;
        book = new;
        send_idle = 36;
        recv_idle = 61;
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // small graph: diagonal, no edge, other flagged weights, max and zero weights; then runs over zero and one node
        load_node_count(7'd4);
        offer_word(apsp_pkg::MODE_WRITE, 0, 0, 17'h0FFFF);
        offer_word(apsp_pkg::MODE_WRITE, 1, 1, 17'h1FFFF);
        offer_word(apsp_pkg::MODE_WRITE, 2, 2, 17'd5);
        offer_word(apsp_pkg::MODE_WRITE, 3, 3, 17'd0);
        offer_word(apsp_pkg::MODE_WRITE, 0, 1, 17'h0FFFF);
        offer_word(apsp_pkg::MODE_WRITE, 1, 2, 17'd0);
        offer_word(apsp_pkg::MODE_WRITE, 0, 2, 17'h1FFFF);
        offer_word(apsp_pkg::MODE_WRITE, 2, 3, 17'h1FFFE);
        offer_word(apsp_pkg::MODE_WRITE, 3, 0, 17'h10000);
        offer_word(apsp_pkg::MODE_WRITE, 1, 3, 17'd7);
        offer_word(apsp_pkg::MODE_WRITE, 0, 3, 17'd100);
        offer_word(apsp_pkg::MODE_WRITE, 1, 0, 17'h1FFFF);
        offer_word(apsp_pkg::MODE_WRITE, 2, 0, 17'd3);
        offer_word(apsp_pkg::MODE_WRITE, 2, 1, 17'd1);
        offer_word(apsp_pkg::MODE_WRITE, 3, 1, 17'd20);
        offer_word(apsp_pkg::MODE_WRITE, 3, 2, 17'h1FFFF);
        offer_word(MODE_NONE, 5, 9, 17'h1ABCD);
        offer_word(apsp_pkg::MODE_RUN, 0, 0, 17'd0);
        offer_word(apsp_pkg::MODE_READ, 0, 1, 17'd0);
        offer_word(apsp_pkg::MODE_READ, 0, 2, 17'd0);
        offer_word(apsp_pkg::MODE_READ, 2, 3, 17'd0);
        offer_word(apsp_pkg::MODE_READ, 3, 0, 17'd0);
        load_node_count(7'd0);
        offer_word(apsp_pkg::MODE_RUN, 0, 0, 17'd0);
        offer_word(apsp_pkg::MODE_READ, 1, 0, 17'd0);
        load_node_count(7'd1);
        offer_word(apsp_pkg::MODE_RUN, 0, 0, 17'd0);
        offer_word(apsp_pkg::MODE_READ, 0, 0, 17'd0);

        // fill the leading block of the store, then close over it
        for (int r = 0; r < FILL_NODES; r++)
            for (int c = 0; c < FILL_NODES; c++)
                offer_word(apsp_pkg::MODE_WRITE, NB'(r), NB'(c), pick_weight());
        load_node_count(7'd16);
        offer_word(apsp_pkg::MODE_RUN, pick_node(), pick_node(), pick_weight());
        repeat (8) offer_word(apsp_pkg::MODE_READ, pick_node(), pick_node(), pick_weight());

        counted = 0;
        next_cfg = 0;
        squeezed = 1'b0;
        while (counted < RANDOM_ITEMS)
        begin
            if (counted >= 2 * RANDOM_ITEMS / 3)
            begin
                send_idle = 0;
                recv_idle = 0;
            end
            else if (counted >= RANDOM_ITEMS / 3)
            begin
                send_idle = 61;
                recv_idle = 36;
            end
            if (counted >= next_cfg)
            begin
                pick = $urandom_range(0, 15);
                if (pick == 0)
                    load_node_count(7'd0);
                else if (pick == 1)
                    load_node_count(7'd16);
                else
                    load_node_count(apsp_pkg::CNT_BITS'($urandom_range(1, 8)));
                next_cfg = counted + $urandom_range(30, 60);
            end
            if (counted >= 60 && !squeezed)
            begin
                // hold the receiver off and keep offering reads until the input stalls
                squeezed = 1'b1;
                stall_left = 300;
                repeat (40)
                    offer_word(apsp_pkg::MODE_READ, pick_node(), pick_node(), pick_weight());
                counted += 40;
            end
            pick = $urandom_range(0, 99);
            if (pick < 5)
                offer_word(MODE_NONE, pick_node(), pick_node(), pick_weight());
            else
            begin
                if (pick < 13)
                    offer_word(apsp_pkg::MODE_RUN, pick_node(), pick_node(), pick_weight());
                else if (pick < 50)
                    offer_word(apsp_pkg::MODE_READ, pick_node(), pick_node(), pick_weight());
                else
                    offer_word(apsp_pkg::MODE_WRITE, pick_far_node(), pick_far_node(),
                               pick_weight());
                counted++;
            end
        end

        drain_results();
        repeat (20) @(posedge clk);
        if (book.pending() != 0)
        begin
            $error("%0d expected words never arrived", book.pending());
            book.failures++;
        end
        if (book.failures == 0)
            $display("all_pairs_shortest_path_test passed");
        else
            $display("all_pairs_shortest_path_test failed");
        $finish;
    end

endmodule
